### rtl/ihex_pkg.sv
`default_nettype none

package ihex_pkg;

    // Line framing constants
    localparam logic [9:0] MIN_LINE  = 10'd11;
    localparam logic [9:0] COUNT_MAX = 10'd1023;
    localparam logic [9:0] DATA_BASE = 10'd9;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;

    // Record types
    localparam logic [7:0] REC_DATA   = 8'h00;
    localparam logic [7:0] REC_EOF    = 8'h01;
    localparam logic [7:0] REC_SEG    = 8'h02;
    localparam logic [7:0] REC_LINEAR = 8'h04;

    // Result kinds
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_COLON   = 3'd1,
        ST_BAD_HEADER = 3'd2,
        ST_TOO_SHORT  = 3'd3,
        ST_BAD_DATA   = 3'd4,
        ST_SHORT_ADDR = 3'd5
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [7:0]  record_length;
        logic [7:0]  record_type;
        logic [7:0]  data_byte;
        logic [7:0]  byte_offset;
        logic [31:0] record_address;
        logic        kind;
    } t_result;

    // Hex digit value; bit 4 set marks a character that is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            v = {1'b0, c[3:0] + 4'd9};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/ihex_core.sv
`default_nettype none

module ihex_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [7:0]        i_char,
    input  wire logic              i_eoi,
    output logic                   o_res_valid,
    output ihex_pkg::t_result      o_res
);

    logic [9:0]  r_count, n_count;
    logic        r_colon, n_colon;
    logic        r_hdr_bad, n_hdr_bad;
    logic        r_dat_bad, n_dat_bad;
    logic [3:0]  r_nibble, n_nibble;
    logic [7:0]  r_len, n_len;
    logic [15:0] r_offset, n_offset;
    logic [7:0]  r_type, n_type;
    logic [31:0] r_upper, n_upper;
    logic [15:0] r_first, n_first;
    logic        r_halted, n_halted;

    logic [4:0]        digit;
    logic [7:0]        byte_val;
    logic [9:0]        line_need;
    logic [9:0]        data_end;
    logic [9:0]        idx_full;
    logic [7:0]        byte_idx;
    ihex_pkg::t_status close_st;
    logic              closing;

    assign digit     = ihex_pkg::hex_value(i_char);
    assign byte_val  = {r_nibble, digit[3:0]};
    assign line_need = ihex_pkg::MIN_LINE + {1'b0, r_len, 1'b0};
    assign data_end  = ihex_pkg::DATA_BASE + {1'b0, r_len, 1'b0};
    assign idx_full  = (r_count - 10'd10) >> 1;
    assign byte_idx  = idx_full[7:0];

    // Status of a line that closes now, first matching error wins.
    always_comb begin
        if (!r_colon) begin
            close_st = ihex_pkg::ST_NO_COLON;
        end else if (r_hdr_bad) begin
            close_st = ihex_pkg::ST_BAD_HEADER;
        end else if (r_count < line_need) begin
            close_st = ihex_pkg::ST_TOO_SHORT;
        end else if (r_dat_bad) begin
            close_st = ihex_pkg::ST_BAD_DATA;
        end else if ((r_type == ihex_pkg::REC_SEG || r_type == ihex_pkg::REC_LINEAR)
                     && r_len < 8'd2) begin
            close_st = ihex_pkg::ST_SHORT_ADDR;
        end else begin
            close_st = ihex_pkg::ST_OK;
        end
    end

    // A line that reaches MIN_LINE closes at newline or end of input, unless halted.
    assign closing = i_fire && !r_halted && (i_eoi || i_char == ihex_pkg::CHAR_NL)
                     && r_count >= ihex_pkg::MIN_LINE;

    // Next state and result for one character.
    always_comb begin
        n_count   = r_count;
        n_colon   = r_colon;
        n_hdr_bad = r_hdr_bad;
        n_dat_bad = r_dat_bad;
        n_nibble  = r_nibble;
        n_len     = r_len;
        n_offset  = r_offset;
        n_type    = r_type;
        n_upper   = r_upper;
        n_first   = r_first;
        n_halted  = r_halted;

        o_res_valid           = 1'b0;
        o_res.kind            = ihex_pkg::KIND_END;
        o_res.record_address  = r_upper + {16'd0, r_offset};
        o_res.byte_offset     = 8'd0;
        o_res.data_byte       = 8'd0;
        o_res.record_type     = r_type;
        o_res.record_length   = r_len;
        o_res.status          = close_st;

        if (closing) begin
            o_res_valid = 1'b1;
        end

        if (i_fire) begin
            if (i_eoi || (!r_halted && i_char == ihex_pkg::CHAR_NL)) begin
                // Line close: update the upper address or halt, then clear the line.
                if (closing) begin
                    if (close_st != ihex_pkg::ST_OK) begin
                        n_halted = 1'b1;
                    end else if (r_type == ihex_pkg::REC_SEG) begin
                        n_upper = {12'd0, r_first, 4'd0};
                    end else if (r_type == ihex_pkg::REC_LINEAR) begin
                        n_upper = {r_first, 16'd0};
                    end
                end
                n_count   = '0;
                n_colon   = 1'b0;
                n_hdr_bad = 1'b0;
                n_dat_bad = 1'b0;
                n_nibble  = '0;
                n_len     = '0;
                n_offset  = '0;
                n_type    = '0;
                n_first   = '0;
                if (i_eoi) begin
                    n_upper  = '0;
                    n_halted = 1'b0;
                end
            end else if (!r_halted) begin
                if (r_count != ihex_pkg::COUNT_MAX) begin
                    n_count = r_count + 10'd1;
                end
                if (r_count == 10'd0) begin
                    n_colon = (i_char == ihex_pkg::CHAR_COLON);
                end else if (r_count <= 10'd8) begin
                    // Header digits: length, offset high, offset low, type.
                    if (digit[4]) begin
                        n_hdr_bad = 1'b1;
                    end else if (r_count[0]) begin
                        n_nibble = digit[3:0];
                    end else begin
                        case (r_count[2:1])
                            2'd1:    n_len = byte_val;
                            2'd2:    n_offset[15:8] = byte_val;
                            2'd3:    n_offset[7:0] = byte_val;
                            default: n_type = byte_val;
                        endcase
                    end
                end else if (r_count < data_end) begin
                    // Data digits: a byte completes on every even data position.
                    if (digit[4]) begin
                        n_dat_bad = 1'b1;
                    end else if (r_count[0]) begin
                        n_nibble = digit[3:0];
                    end else begin
                        if (byte_idx == 8'd0) begin
                            n_first[15:8] = byte_val;
                        end else if (byte_idx == 8'd1) begin
                            n_first[7:0] = byte_val;
                        end
                        if (r_colon && !r_hdr_bad && !r_dat_bad
                            && r_type == ihex_pkg::REC_DATA) begin
                            o_res_valid       = 1'b1;
                            o_res.kind        = ihex_pkg::KIND_DATA;
                            o_res.byte_offset = byte_idx;
                            o_res.data_byte   = byte_val;
                            o_res.status      = ihex_pkg::ST_OK;
                        end
                    end
                end
            end
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_colon   <= 1'b0;
            r_hdr_bad <= 1'b0;
            r_dat_bad <= 1'b0;
            r_nibble  <= '0;
            r_len     <= '0;
            r_offset  <= '0;
            r_type    <= '0;
            r_upper   <= '0;
            r_first   <= '0;
            r_halted  <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_colon   <= n_colon;
            r_hdr_bad <= n_hdr_bad;
            r_dat_bad <= n_dat_bad;
            r_nibble  <= n_nibble;
            r_len     <= n_len;
            r_offset  <= n_offset;
            r_type    <= n_type;
            r_upper   <= n_upper;
            r_first   <= n_first;
            r_halted  <= n_halted;
        end
    end

    // A halted parser never emits a data byte.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halted && o_res_valid) |-> (o_res.kind == ihex_pkg::KIND_END))
        else $error("data byte emitted while halted");

    // Every error closing that is not at end of input halts the parser.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (closing && !i_eoi && close_st != ihex_pkg::ST_OK) |=> r_halted)
        else $error("error close did not halt");

    // End of input always leaves an empty line.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_eoi) |=> (r_count == 10'd0 && !r_halted && r_upper == 32'd0))
        else $error("end of input did not clear state");

endmodule

`default_nettype wire

### rtl/intel_hex_record_parser_top.sv
// Intel HEX record parser, one character per transaction.
// A character waits in the input register; its result is registered in the result or skid entry.
// Throughput: one character per cycle if the skid entry is free; one parser step per character.
// A two-entry output buffer (result register and skid register) decouples back-pressure.
// Reset (i_rst_n low at a clock edge) clears the line state, upper address, halt and buffers.
`default_nettype none

module intel_hex_record_parser_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tlast,   // end_of_input
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] record_address, [39:32] byte_offset, [47:40] data_byte,
    // [55:48] record_type, [63:56] record_length, [66:64] status, [71:67] zero
    output logic [71:0]      m_axis_tdata,
    output logic             m_axis_tuser    // kind
);

    logic                r_in_valid;
    logic [7:0]          r_in_char;
    logic                r_in_eoi;
    logic                r_out_valid;
    ihex_pkg::t_result   r_out;
    logic                r_skid_valid;
    ihex_pkg::t_result   r_skid;
    logic                proc;
    logic                out_take;
    logic                res_valid;
    ihex_pkg::t_result   res;

    // The parser steps when a character is held and the skid entry is free.
    assign proc          = r_in_valid && !r_skid_valid;
    assign s_axis_tready = !r_in_valid || proc;
    assign out_take      = r_out_valid && m_axis_tready;

    ihex_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (proc),
        .i_char      (r_in_char),
        .i_eoi       (r_in_eoi),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
            r_in_eoi  <= s_axis_tlast;
        end
    end

    // Result register and skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || out_take) begin
                r_out_valid  <= r_skid_valid || (proc && res_valid);
                r_skid_valid <= 1'b0;
            end else if (proc && res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (proc && res_valid) begin
            r_skid <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tdata  = {5'd0, r_out.status, r_out.record_length, r_out.record_type,
                            r_out.data_byte, r_out.byte_offset, r_out.record_address};

    // The skid entry is only used behind a stalled result.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry filled with empty result register");

    // A stalled result holds its contents.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // Data bytes always carry a clean status.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == ihex_pkg::KIND_DATA) |-> (r_out.status == ihex_pkg::ST_OK))
        else $error("data byte with error status");

endmodule

`default_nettype wire
